FILE: hdl/rcci_pkg.sv
package rcci_pkg;

  // field widths
  localparam int POS_W = 17;
  localparam int DIR_W = 16;
  localparam int LEN_W = 16;
  localparam int THR_W = 31;
  localparam int CFG_W = 31;
  localparam int IDX_W = 2;
  localparam int OUT_W = 23;
  localparam int ST_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_HALF   = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic [LEN_W-1:0] RADIUS_RST = 16'd21750;
  localparam logic [LEN_W-1:0] HALF_RST   = 16'd22000;
  localparam logic [THR_W-1:0] THRESH_RST = 31'd10737;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
  localparam logic [ST_W-1:0] ST_DEGEN = 2'd2;

  // internal widths
  localparam int A_W     = 2 * DIR_W;
  localparam int B_W     = POS_W + DIR_W + 1;
  localparam int C_W     = 2 * POS_W + 1;
  localparam int Q_W     = A_W + C_W - 1;
  localparam int SQ_FRAC = 38;
  localparam int RAD_W   = Q_W + SQ_FRAC;
  localparam int S_W     = RAD_W / 2;
  localparam int REM_W   = S_W + 3;
  localparam int T_FRAC  = 19;
  localparam int NUM_W   = 55;
  localparam int HZ_W    = POS_W + 1;
  localparam int PROD_W  = NUM_W + DIR_W;
  localparam int LIM_W   = HZ_W + A_W + 1;
  localparam int CMP_W   = PROD_W + 1;
  localparam int R_W     = NUM_W + 2;
  localparam int QB      = 24;

  typedef struct packed {
    logic                    valid;
    logic                    axial;
    logic                    miss;
    logic signed [B_W-1:0]   b;
    logic [A_W-1:0]          a;
    logic signed [POS_W-1:0] pz;
    logic signed [DIR_W-1:0] dz;
  } sq_side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [S_W-1:0]   root;
    logic [RAD_W-1:0] rad;
  } sq_data_t;

  typedef struct packed {
    logic [R_W-1:0] rem;
    logic [R_W-1:0] dsh;
    logic [QB-1:0]  quo;
    logic           neg;
  } div_lane_t;

  typedef struct packed {
    logic            valid;
    logic [ST_W-1:0] status;
  } div_side_t;

endpackage

FILE: hdl/rcci_sqrt_cell.sv
module rcci_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  rcci_pkg::sq_side_t side_in,
  input  rcci_pkg::sq_data_t data_in,
  output rcci_pkg::sq_side_t side_out,
  output rcci_pkg::sq_data_t data_out
);
  import rcci_pkg::*;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic             fits;
  sq_data_t         data_next;

  // one root bit per cell, two radicand bits enter the remainder
  always_comb begin
    shifted = {data_in.rem[REM_W-3:0], data_in.rad[RAD_W-1 -: 2]};
    trial = {{(REM_W-S_W-2){1'b0}}, data_in.root, 2'b01};
    fits = shifted >= trial;
    data_next.rem = fits ? shifted - trial : shifted;
    data_next.root = {data_in.root[S_W-2:0], fits};
    data_next.rad = {data_in.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
    side_out <= side_in;
    if (rst) begin
      side_out.valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/rcci_div_cell.sv
module rcci_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  rcci_pkg::div_side_t side_in,
  input  rcci_pkg::div_lane_t ent_in,
  input  rcci_pkg::div_lane_t ext_in,
  output rcci_pkg::div_side_t side_out,
  output rcci_pkg::div_lane_t ent_out,
  output rcci_pkg::div_lane_t ext_out
);
  import rcci_pkg::*;

  // one quotient bit per cell, divisor moves right
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t r;
    logic      fits;
    fits = l.rem >= l.dsh;
    r.rem = fits ? l.rem - l.dsh : l.rem;
    r.dsh = l.dsh >> 1;
    r.quo = {l.quo[QB-2:0], fits};
    r.neg = l.neg;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    ent_out <= div_step(ent_in);
    ext_out <= div_step(ext_in);
    side_out <= side_in;
    if (rst) begin
      side_out.valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/ray_capped_cylinder_intersect_top.sv
// Line to capped cylinder intersection, fully pipelined. One item is taken in every
// clock cycle (busy is always low) and its result shows on done, entry_distance,
// exit_distance and status for exactly one cycle; results leave in order and cannot be
// held off. The pipeline is made of two rows of cells: 52 square-root cells (one root
// bit each) and 24 divider cells (one quotient bit each, entry and exit side by side),
// plus eight stages for the products, the discriminant, the cap test and the
// saturation. Registers may only be written while no item is in flight.
module ray_capped_cylinder_intersect_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rcci_pkg::POS_W-1:0]  pos_x,
  input  logic signed [rcci_pkg::POS_W-1:0]  pos_y,
  input  logic signed [rcci_pkg::POS_W-1:0]  pos_z,
  input  logic signed [rcci_pkg::DIR_W-1:0]  dir_x,
  input  logic signed [rcci_pkg::DIR_W-1:0]  dir_y,
  input  logic signed [rcci_pkg::DIR_W-1:0]  dir_z,
  input  logic                               cfg_write,
  input  logic [rcci_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rcci_pkg::CFG_W-1:0]         cfg_data,
  output logic                               done,
  output logic signed [rcci_pkg::OUT_W-1:0]  entry_distance,
  output logic signed [rcci_pkg::OUT_W-1:0]  exit_distance,
  output logic [rcci_pkg::ST_W-1:0]          status
);
  import rcci_pkg::*;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [QB-1:0]           SAT_LIM = QB'(1) << (OUT_W-1);

  // configuration registers
  logic [LEN_W-1:0] cylinder_radius;
  logic [LEN_W-1:0] half_height;
  logic [THR_W-1:0] axis_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cylinder_radius <= RADIUS_RST;
      half_height <= HALF_RST;
      axis_threshold <= THRESH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS: cylinder_radius <= cfg_data[LEN_W-1:0];
        REG_HALF:   half_height <= cfg_data[LEN_W-1:0];
        REG_THRESH: axis_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // never stalls
  assign busy = 1'b0;

  // input register
  logic                    v0;
  logic signed [POS_W-1:0] s0_px, s0_py, s0_pz;
  logic signed [DIR_W-1:0] s0_dx, s0_dy, s0_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    if (start) begin
      s0_px <= pos_x;
      s0_py <= pos_y;
      s0_pz <= pos_z;
      s0_dx <= dir_x;
      s0_dy <= dir_y;
      s0_dz <= dir_z;
    end
  end

  // stage 1: transverse terms a, b and c
  logic signed [A_W-1:0]       dxx, dyy;
  logic signed [B_W-2:0]       bx, by;
  logic signed [2*POS_W-1:0]   pxx, pyy;
  logic [2*POS_W-1:0]          p2;
  logic [A_W-1:0]              rsq;
  logic [A_W-1:0]              a_comb;

  always_comb begin
    dxx = s0_dx * s0_dx;
    dyy = s0_dy * s0_dy;
    bx = s0_px * s0_dx;
    by = s0_py * s0_dy;
    pxx = s0_px * s0_px;
    pyy = s0_py * s0_py;
    p2 = $unsigned(pxx) + $unsigned(pyy);
    rsq = cylinder_radius * cylinder_radius;
    a_comb = $unsigned(dxx) + $unsigned(dyy);
  end

  logic                    v1;
  logic [A_W-1:0]          s1_a;
  logic signed [B_W-1:0]   s1_b;
  logic signed [C_W-1:0]   s1_c;
  logic                    s1_axial;
  logic signed [POS_W-1:0] s1_pz;
  logic signed [DIR_W-1:0] s1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1_a <= a_comb;
    s1_b <= {bx[B_W-2], bx} + {by[B_W-2], by};
    s1_c <= {1'b0, p2} - {{(C_W-A_W){1'b0}}, rsq};
    // zero transverse direction is always axial
    s1_axial <= (a_comb < {1'b0, axis_threshold}) || (a_comb == '0);
    s1_pz <= s0_pz;
    s1_dz <= s0_dz;
  end

  // stage 2: b squared and a times |c|
  logic signed [B_W-1:0] b_neg;
  logic signed [C_W-1:0] c_neg;
  logic [B_W-2:0]        b_mag;
  logic [C_W-2:0]        c_mag;

  always_comb begin
    b_neg = -s1_b;
    c_neg = -s1_c;
    b_mag = s1_b[B_W-1] ? b_neg[B_W-2:0] : s1_b[B_W-2:0];
    c_mag = s1_c[C_W-1] ? c_neg[C_W-2:0] : s1_c[C_W-2:0];
  end

  logic                    v2;
  logic [Q_W-1:0]          s2_bsq, s2_ac;
  logic                    s2_cpos;
  logic [A_W-1:0]          s2_a;
  logic signed [B_W-1:0]   s2_b;
  logic                    s2_axial;
  logic signed [POS_W-1:0] s2_pz;
  logic signed [DIR_W-1:0] s2_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_bsq <= b_mag * b_mag;
    s2_ac <= s1_a * c_mag;
    s2_cpos <= !s1_c[C_W-1] && (s1_c != '0);
    s2_a <= s1_a;
    s2_b <= s1_b;
    s2_axial <= s1_axial;
    s2_pz <= s1_pz;
    s2_dz <= s1_dz;
  end

  // stage 3: discriminant, head of the square-root row
  sq_side_t sq_side [0:S_W];
  sq_data_t sq_data [0:S_W];

  always_ff @(posedge clk) begin
    sq_side[0].valid <= rst ? 1'b0 : v2;
    sq_side[0].axial <= s2_axial;
    // negative discriminant: the line passes the wall
    sq_side[0].miss <= s2_cpos && (s2_ac > s2_bsq);
    sq_side[0].b <= s2_b;
    sq_side[0].a <= s2_a;
    sq_side[0].pz <= s2_pz;
    sq_side[0].dz <= s2_dz;
    sq_data[0].rem <= '0;
    sq_data[0].root <= '0;
    sq_data[0].rad <= {(s2_cpos ? s2_bsq - s2_ac : s2_bsq + s2_ac), {SQ_FRAC{1'b0}}};
  end

  for (genvar i = 0; i < S_W; i++) begin : g_sqrt
    rcci_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (sq_side[i]),
      .data_in  (sq_data[i]),
      .side_out (sq_side[i+1]),
      .data_out (sq_data[i+1])
    );
  end

  // post stage 1: wall numerators and cap offsets
  sq_side_t              sq_end;
  logic signed [NUM_W-1:0] b_ext, base, s_ext;
  logic signed [HZ_W-1:0]  h_ext, pz_ext;

  always_comb begin
    sq_end = sq_side[S_W];
    b_ext = {{(NUM_W-B_W){sq_end.b[B_W-1]}}, sq_end.b};
    base = -(b_ext <<< T_FRAC);
    s_ext = $signed({{(NUM_W-S_W){1'b0}}, sq_data[S_W].root});
    h_ext = $signed({{(HZ_W-LEN_W){1'b0}}, half_height});
    pz_ext = {sq_end.pz[POS_W-1], sq_end.pz};
  end

  logic                    v_p1;
  logic signed [NUM_W-1:0] p1_ne, p1_nx;
  logic signed [HZ_W-1:0]  p1_hm, p1_hp;
  logic [A_W-1:0]          p1_a;
  logic signed [DIR_W-1:0] p1_dz;
  logic                    p1_axial, p1_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1 <= 1'b0;
    end else begin
      v_p1 <= sq_end.valid;
    end
    p1_ne <= base - s_ext;
    p1_nx <= base + s_ext;
    p1_hm <= -h_ext - pz_ext;
    p1_hp <= h_ext - pz_ext;
    p1_a <= sq_end.a;
    p1_dz <= sq_end.dz;
    p1_axial <= sq_end.axial;
    p1_miss <= sq_end.miss;
  end

  // post stage 2: products for the exact cap test
  logic                     v_p2;
  logic signed [PROD_W-1:0] p2_pe, p2_px;
  logic signed [LIM_W-1:0]  p2_lo, p2_hi;
  logic signed [NUM_W-1:0]  p2_ne, p2_nx;
  logic signed [HZ_W-1:0]   p2_hm, p2_hp;
  logic [A_W-1:0]           p2_a;
  logic signed [DIR_W-1:0]  p2_dz;
  logic                     p2_axial, p2_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p2 <= 1'b0;
    end else begin
      v_p2 <= v_p1;
    end
    p2_pe <= p1_ne * p1_dz;
    p2_px <= p1_nx * p1_dz;
    p2_lo <= p1_hm * $signed({1'b0, p1_a});
    p2_hi <= p1_hp * $signed({1'b0, p1_a});
    p2_ne <= p1_ne;
    p2_nx <= p1_nx;
    p2_hm <= p1_hm;
    p2_hp <= p1_hp;
    p2_a <= p1_a;
    p2_dz <= p1_dz;
    p2_axial <= p1_axial;
    p2_miss <= p1_miss;
  end

  // post stage 3: cap test, choose wall or cap division per side
  logic signed [CMP_W-1:0] pe_c, px_c, lo_c, hi_c;
  logic                    out_e, out_x, dz_zero, dz_pos;
  logic signed [HZ_W-1:0]  lim_e, lim_x;
  logic signed [NUM_W-1:0] cap_e, cap_x;
  logic signed [DIR_W-1:0] dz_neg;
  logic [A_W-1:0]          dz_den;
  logic                    cap_use_e, cap_use_x;
  logic [ST_W-1:0]         st_comb;

  always_comb begin
    pe_c = $signed({{(CMP_W-PROD_W){p2_pe[PROD_W-1]}}, p2_pe});
    px_c = $signed({{(CMP_W-PROD_W){p2_px[PROD_W-1]}}, p2_px});
    lo_c = $signed({{(CMP_W-LIM_W){p2_lo[LIM_W-1]}}, p2_lo}) <<< T_FRAC;
    hi_c = $signed({{(CMP_W-LIM_W){p2_hi[LIM_W-1]}}, p2_hi}) <<< T_FRAC;
    out_e = (pe_c < lo_c) || (pe_c > hi_c);
    out_x = (px_c < lo_c) || (px_c > hi_c);
    dz_zero = p2_dz == '0;
    dz_pos = !p2_dz[DIR_W-1] && !dz_zero;
    // entry cap is the lower one when moving up
    lim_e = dz_pos ? p2_hm : p2_hp;
    lim_x = dz_pos ? p2_hp : p2_hm;
    cap_e = $signed({{(NUM_W-HZ_W){lim_e[HZ_W-1]}}, lim_e}) <<< T_FRAC;
    cap_x = $signed({{(NUM_W-HZ_W){lim_x[HZ_W-1]}}, lim_x}) <<< T_FRAC;
    dz_neg = -p2_dz;
    dz_den = {{(A_W-DIR_W){1'b0}}, (p2_dz[DIR_W-1] ? $unsigned(dz_neg) : $unsigned(p2_dz))};
    cap_use_e = p2_axial || out_e;
    cap_use_x = p2_axial || out_x;
    if (p2_axial) begin
      st_comb = dz_zero ? ST_DEGEN : ST_OK;
    end else if (p2_miss) begin
      st_comb = ST_MISS;
    end else if ((out_e || out_x) && dz_zero) begin
      st_comb = ST_DEGEN;
    end else begin
      st_comb = ST_OK;
    end
  end

  logic                    v_p3;
  logic [ST_W-1:0]         p3_status;
  logic signed [NUM_W-1:0] p3_ne, p3_nx;
  logic [A_W-1:0]          p3_de, p3_dx;
  logic                    p3_sge, p3_sgx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p3 <= 1'b0;
    end else begin
      v_p3 <= v_p2;
    end
    p3_status <= st_comb;
    p3_ne <= cap_use_e ? cap_e : p2_ne;
    p3_nx <= cap_use_x ? cap_x : p2_nx;
    p3_de <= cap_use_e ? dz_den : p2_a;
    p3_dx <= cap_use_x ? dz_den : p2_a;
    p3_sge <= cap_use_e ? (lim_e[HZ_W-1] != p2_dz[DIR_W-1]) : p2_ne[NUM_W-1];
    p3_sgx <= cap_use_x ? (lim_x[HZ_W-1] != p2_dz[DIR_W-1]) : p2_nx[NUM_W-1];
  end

  // post stage 4: rounding numerator 2n+d over 2d, head of the divider row
  logic signed [NUM_W-1:0] ne_neg, nx_neg;
  logic [NUM_W-1:0]        ne_mag, nx_mag;

  always_comb begin
    ne_neg = -p3_ne;
    nx_neg = -p3_nx;
    ne_mag = p3_ne[NUM_W-1] ? $unsigned(ne_neg) : $unsigned(p3_ne);
    nx_mag = p3_nx[NUM_W-1] ? $unsigned(nx_neg) : $unsigned(p3_nx);
  end

  div_side_t dv_side [0:QB];
  div_lane_t dv_ent  [0:QB];
  div_lane_t dv_ext  [0:QB];

  always_ff @(posedge clk) begin
    dv_side[0].valid <= rst ? 1'b0 : v_p3;
    dv_side[0].status <= p3_status;
    dv_ent[0].rem <= {1'b0, ne_mag, 1'b0} + R_W'(p3_de);
    dv_ent[0].dsh <= R_W'(p3_de) << QB;
    dv_ent[0].quo <= '0;
    dv_ent[0].neg <= p3_sge;
    dv_ext[0].rem <= {1'b0, nx_mag, 1'b0} + R_W'(p3_dx);
    dv_ext[0].dsh <= R_W'(p3_dx) << QB;
    dv_ext[0].quo <= '0;
    dv_ext[0].neg <= p3_sgx;
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    rcci_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (dv_side[j]),
      .ent_in   (dv_ent[j]),
      .ext_in   (dv_ext[j]),
      .side_out (dv_side[j+1]),
      .ent_out  (dv_ent[j+1]),
      .ext_out  (dv_ext[j+1])
    );
  end

  // saturate the rounded quotient; a set top bit already means out of range
  function automatic logic signed [OUT_W-1:0] sat_out(div_lane_t l);
    logic signed [OUT_W-1:0] v;
    v = $signed(l.quo[OUT_W-1:0]);
    if (l.neg) begin
      return (l.quo > SAT_LIM) ? OUT_MIN : -v;
    end
    return (l.quo >= SAT_LIM) ? OUT_MAX : v;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_side[QB].valid;
    end
    status <= dv_side[QB].status;
    // miss or degenerate: both distances read zero
    if (dv_side[QB].status != ST_OK) begin
      entry_distance <= '0;
      exit_distance <= '0;
    end else begin
      entry_distance <= sat_out(dv_ent[QB]);
      exit_distance <= sat_out(dv_ext[QB]);
    end
  end

endmodule

FILE: tb/sv/rcci_checker.sv
// watches the item and result channels, predicts each result and compares
module rcci_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [rcci_pkg::POS_W-1:0] pos_x,
  input  logic signed [rcci_pkg::POS_W-1:0] pos_y,
  input  logic signed [rcci_pkg::POS_W-1:0] pos_z,
  input  logic signed [rcci_pkg::DIR_W-1:0] dir_x,
  input  logic signed [rcci_pkg::DIR_W-1:0] dir_y,
  input  logic signed [rcci_pkg::DIR_W-1:0] dir_z,
  input  logic                              cfg_write,
  input  logic [rcci_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rcci_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              done,
  input  logic signed [rcci_pkg::OUT_W-1:0] entry_distance,
  input  logic signed [rcci_pkg::OUT_W-1:0] exit_distance,
  input  logic [rcci_pkg::ST_W-1:0]         status,
  output int                                errors = 0,
  output int                                pending = 0
);
  import rcci_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [OUT_W-1:0] ent;
    logic signed [OUT_W-1:0] ext;
    logic [ST_W-1:0]         st;
  } crossing_t;

  crossing_t expected_crossings[$];
  logic [LEN_W-1:0] radius_q;
  logic [LEN_W-1:0] half_q;
  logic [THR_W-1:0] thresh_q;
  int err_count = 0;

  // nearest, halves away from zero
  function automatic wide_t round_div(wide_t num, wide_t den);
    wide_t n;
    wide_t d;
    wide_t q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip(wide_t v);
    if (v > 4194303) return {1'b0, {(OUT_W-1){1'b1}}};
    if (v < -4194304) return {1'b1, {(OUT_W-1){1'b0}}};
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = res | (128'd1 << k);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  function automatic wide_t cap_t(wide_t lim, wide_t pz, wide_t dz);
    return round_div((lim - pz) * 524288, dz);
  endfunction

  // wall hit with numerator n has z beyond one of the caps
  function automatic bit beyond_caps(wide_t n, wide_t a, wide_t pz, wide_t dz, wide_t h);
    wide_t p;
    p = n * dz;
    return (p < (-h - pz) * 524288 * a) || (p > (h - pz) * 524288 * a);
  endfunction

  function automatic crossing_t predict_crossing(wide_t px, wide_t py, wide_t pz,
                                                 wide_t dx, wide_t dy, wide_t dz);
    crossing_t res;
    wide_t a, b, c, q, s, ne, nx, h, r, thr, ent, ext;
    logic [127:0] rad;
    h = {112'd0, half_q};
    r = {112'd0, radius_q};
    thr = {97'd0, thresh_q};
    a = dx * dx + dy * dy;
    ent = 0;
    ext = 0;
    res.st = ST_OK;
    if (a < thr || a == 0) begin
      if (dz == 0) begin
        res.st = ST_DEGEN;
      end else begin
        ent = cap_t(dz > 0 ? -h : h, pz, dz);
        ext = cap_t(dz > 0 ? h : -h, pz, dz);
      end
    end else begin
      b = px * dx + py * dy;
      c = px * px + py * py - r * r;
      q = b * b - a * c;
      if (q < 0) begin
        res.st = ST_MISS;
      end else begin
        rad = q;
        s = isqrt(rad << 38);
        ne = -(b * 524288) - s;
        nx = -(b * 524288) + s;
        ent = round_div(ne, a);
        ext = round_div(nx, a);
        if (beyond_caps(ne, a, pz, dz, h)) begin
          if (dz == 0) res.st = ST_DEGEN;
          else ent = cap_t(dz > 0 ? -h : h, pz, dz);
        end
        if (beyond_caps(nx, a, pz, dz, h)) begin
          if (dz == 0) res.st = ST_DEGEN;
          else ext = cap_t(dz > 0 ? h : -h, pz, dz);
        end
        if (res.st == ST_DEGEN) begin
          ent = 0;
          ext = 0;
        end
      end
    end
    res.ent = clip(ent);
    res.ext = clip(ext);
    return res;
  endfunction

  always @(posedge clk) begin
    crossing_t got;
    if (rst) begin
      radius_q <= RADIUS_RST;
      half_q <= HALF_RST;
      thresh_q <= THRESH_RST;
      expected_crossings.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RADIUS: radius_q <= cfg_data[LEN_W-1:0];
          REG_HALF:   half_q <= cfg_data[LEN_W-1:0];
          REG_THRESH: thresh_q <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_crossings.push_back(predict_crossing(pos_x, pos_y, pos_z,
                                                      dir_x, dir_y, dir_z));
      if (done) begin
        if (expected_crossings.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result ent=%0d ext=%0d st=%0d", $time,
                   entry_distance, exit_distance, status);
        end else begin
          got = expected_crossings.pop_front();
          if (entry_distance !== got.ent) begin
            err_count++;
            $display("%0t: entry_distance expected %0d actual %0d", $time, got.ent,
                     entry_distance);
          end
          if (exit_distance !== got.ext) begin
            err_count++;
            $display("%0t: exit_distance expected %0d actual %0d", $time, got.ext,
                     exit_distance);
          end
          if (status !== got.st) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, got.st, status);
          end
        end
      end
    end
    errors <= err_count;
    pending <= expected_crossings.size();
  end

endmodule

FILE: tb/sv/tb_ray_capped_cylinder_intersect_top.sv
// stimulus and verdict; all prediction and checking lives in rcci_checker
module tb_ray_capped_cylinder_intersect_top;
  import rcci_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic signed [OUT_W-1:0] entry_distance, exit_distance;
  logic [ST_W-1:0] status;
  int errors;
  int pending;

  ray_capped_cylinder_intersect_top dut (.*);

  rcci_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #10000000;
    $display("FAIL ray_capped_cylinder_intersect_top");
    $finish;
  end

  // present one item, hold until taken, then maybe idle for a random gap
  task automatic send_item(int px, int py, int pz, int dx, int dy, int dz);
    int gap;
    start <= 1'b1;
    pos_x <= POS_W'(px);
    pos_y <= POS_W'(py);
    pos_z <= POS_W'(pz);
    dir_x <= DIR_W'(dx);
    dir_y <= DIR_W'(dy);
    dir_z <= DIR_W'(dz);
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every item in flight has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_cylinder(int unsigned rad, int unsigned hh, int unsigned thr);
    write_reg(REG_RADIUS, CFG_W'(rad));
    write_reg(REG_HALF, CFG_W'(hh));
    write_reg(REG_THRESH, CFG_W'(thr));
  endtask

  function automatic int pick_pos();
    case ($urandom_range(0, 3))
      0: return -65536;
      1: return 65535;
      2: return 0;
      default: return $urandom_range(0, 131071) - 65536;
    endcase
  endfunction

  function automatic int pick_dir();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // mostly lines near the cylinder, plus axial, flat, null and raw noise
  task automatic send_random();
    int px, py, pz, dx, dy, dz;
    px = $urandom_range(0, 60000) - 30000;
    py = $urandom_range(0, 60000) - 30000;
    pz = $urandom_range(0, 60000) - 30000;
    dx = $urandom_range(0, 65535) - 32768;
    dy = $urandom_range(0, 65535) - 32768;
    dz = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 9))
      5: begin
        px = $urandom_range(0, 131071) - 65536;
        py = $urandom_range(0, 131071) - 65536;
        pz = $urandom_range(0, 131071) - 65536;
      end
      6: begin
        // near the axis direction, around the threshold
        dx = $urandom_range(0, 1) ? 0 : $urandom_range(0, 200) - 100;
        dy = $urandom_range(0, 1) ? 0 : $urandom_range(0, 200) - 100;
      end
      7: dz = 0;
      8: begin
        dx = $urandom_range(0, 4) - 2;
        dy = $urandom_range(0, 4) - 2;
        dz = $urandom_range(0, 4) - 2;
      end
      9: begin
        px = pick_pos();
        py = pick_pos();
        pz = pick_pos();
        dx = pick_dir();
        dy = pick_dir();
        dz = pick_dir();
      end
      default: ;
    endcase
    send_item(px, py, pz, dx, dy, dz);
  endtask

  task automatic send_burst(int n);
    repeat (n) send_random();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: field extremes and the special cases
    send_item(-65536, -65536, -65536, -32768, -32768, -32768);
    send_item(65535, 65535, 65535, 32767, 32767, 32767);
    send_item(0, 0, 0, 0, 0, 0);                 // null direction
    send_item(100, -200, 5000, 0, 0, 0);
    send_item(0, 0, 0, 0, 0, 32767);             // straight up the axis
    send_item(0, 0, 1000, 0, 0, -32768);         // straight down
    send_item(40000, 0, 0, 0, 0, 16384);         // axial but outside the wall
    send_item(5, 5, 5, 10, -10, 0);              // axial, flat
    send_item(0, 0, 0, 16384, 0, 0);             // flat through the centre
    send_item(0, 0, 30000, 16384, 0, 0);         // flat above the cap
    send_item(0, 0, -30000, 0, 16384, 0);        // flat below the cap
    send_item(50000, 0, 0, 0, 16384, 0);         // misses the wall
    send_item(-50000, 50000, 0, 16384, 16384, 100);
    send_item(21750, 0, 0, 0, 16384, 0);         // tangent to the wall
    send_item(-60000, 0, 0, 32767, 0, 1000);     // enters through the wall
    send_item(-60000, 0, 0, 32767, 0, 30000);    // wall hit beyond the cap
    send_item(0, 0, 0, 1, 0, 32767);             // just off the axis, still axial
    send_item(65535, -65536, 65535, 1, 1, -1);   // tiny direction, saturation
    send_item(0, 0, -65536, -32768, 32767, 1);
    send_item(1000, 2000, 0, 103, 2, -32768);    // near the threshold
    send_burst(100);

    // largest cylinder, every off-axis line counts as wall
    drain();
    set_cylinder(65535, 65535, 0);
    send_item(0, 0, 0, 0, 0, 32767);             // zero transverse with threshold 0
    send_item(0, 0, 0, 0, 0, 0);
    send_burst(100);

    // smallest cylinder, axial band up to 2^30
    drain();
    set_cylinder(1, 1, 32'h4000_0000);
    send_burst(100);

    // threshold with every bit set
    drain();
    set_cylinder(1000, 500, 32'h7FFF_FFFF);
    send_burst(60);

    repeat (3) begin
      drain();
      set_cylinder($urandom_range(1, 65535), $urandom_range(1, 65535),
                   $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                        : $urandom_range(0, 32'h4000_0000));
      send_burst(90);
    end

    drain();
    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS ray_capped_cylinder_intersect_top");
    else
      $display("FAIL ray_capped_cylinder_intersect_top");
    $finish;
  end

endmodule
